// ===== rtl/rvaa_pkg.sv =====
// shared types, constants and step functions for the axis rotation block
package rvaa_pkg;

  localparam int COMP_W        = 24;
  localparam int ANGLE_W       = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int IN_W          = 6 * COMP_W + ANGLE_W;
  localparam int OUT_W         = 3 * COMP_W;
  localparam int SQ_STEPS      = 32;
  localparam int DIV_STEPS     = 31;
  localparam int S_H           = 1;
  localparam int S_SH          = 2;
  localparam int S_SQ0         = 3;
  localparam int S_NUM         = S_SQ0 + SQ_STEPS;
  localparam int S_DV0         = S_NUM + 1;
  localparam int FE_STAGES     = S_DV0 + DIV_STEPS;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [35:0] ONE_Q30      = 36'sh040000000;
  localparam logic signed [35:0] HALF_Q30     = 36'sh020000000;

  localparam logic [31:0] ATAN [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic                       vld;
    logic [2:0][COMP_W-1:0]     vec;
    logic [2:0]                 neg;
    logic                       zero;
    logic [2:0][31:0]           mag;
    logic [63:0]                len;
    logic [4:0]                 h;
    logic [63:0]                res;
    logic [2:0][62:0]           dn;
    logic [2:0][31:0]           rem;
    logic [2:0][30:0]           q;
    logic signed [33:0]         cx;
    logic signed [33:0]         cy;
    logic signed [32:0]         cz;
    logic                       flip;
  } fe_t;

  typedef struct packed {
    logic                       vld;
    logic [2:0][2:0][55:0]      prod;
  } mx_t;

  function automatic fe_t sqrt_step(fe_t t, int k);
    logic [63:0] b;
    b = 64'd1 << (62 - 2 * k);
    if (t.len >= t.res + b) begin
      t.len = t.len - (t.res + b);
      t.res = (t.res >> 1) + b;
    end else begin
      t.res = t.res >> 1;
    end
    return t;
  endfunction

  function automatic fe_t cordic_step(fe_t t, int i);
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    dx = t.cy >>> i;
    dy = t.cx >>> i;
    if (t.cz >= 0) begin
      t.cx = t.cx - dx;
      t.cy = t.cy + dy;
      t.cz = t.cz - $signed({1'b0, ATAN[i]});
    end else begin
      t.cx = t.cx + dx;
      t.cy = t.cy - dy;
      t.cz = t.cz + $signed({1'b0, ATAN[i]});
    end
    return t;
  endfunction

  function automatic fe_t div_step(fe_t t, int j);
    logic [32:0] tt;
    for (int i = 0; i < 3; i++) begin
      tt = {t.rem[i], t.dn[i][30-j]};
      if (tt >= {1'b0, t.res[31:0]}) begin
        t.rem[i] = 32'(tt - {1'b0, t.res[31:0]});
        t.q[i]   = {t.q[i][29:0], 1'b1};
      end else begin
        t.rem[i] = tt[31:0];
        t.q[i]   = {t.q[i][29:0], 1'b0};
      end
    end
    return t;
  endfunction

  function automatic logic signed [35:0] rnd30(logic signed [65:0] p);
    logic signed [65:0] s;
    s = p + 66'(HALF_Q30);
    return 36'(s >>> 30);
  endfunction

  function automatic logic signed [31:0] clamp30(logic signed [35:0] v);
    if (v > ONE_Q30) return 32'(ONE_Q30);
    if (v < -ONE_Q30) return 32'(-ONE_Q30);
    return 32'(v);
  endfunction

endpackage

// ===== rtl/vector_rotate_about_axis.sv =====
// top level: rotation of a vector about an arbitrary axis
// Rotates a Q11.12 vector about an axis of any length by a binary angle and
// saturates the result, flagging any clipped component in out_tuser. A new
// item is taken every cycle while the output is not held; each one passes
// through the 32-step square root and the 31-step divider of the axis
// normalisation, then five matrix stages and the output register. When the
// output is held, the whole pipeline holds with it.
module vector_rotate_about_axis import rvaa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // rot_x, rot_y, rot_z
  output logic [OUT_W-1:0] out_tdata,
  // saturated
  output logic             out_tuser
);

  localparam logic signed [27:0] HI = 28'sd2 ** (COMP_W - 1) - 28'sd1;
  localparam logic signed [27:0] LO = -HI - 28'sd1;

  logic ce;
  fe_t  fe;
  mx_t  mx;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             out_sat_r, out_sat_nxt;

  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;

  rvaa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_vld  (in_tvalid),
    .in_data (in_tdata),
    .fe_out  (fe)
  );

  rvaa_matrix u_matrix (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .fe_in  (fe),
    .mx_out (mx)
  );

  always_comb begin
    logic signed [57:0] acc;
    logic signed [27:0] r;
    out_sat_nxt  = 1'b0;
    out_data_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      acc = 58'($signed(mx.prod[i][0])) + 58'($signed(mx.prod[i][1]))
          + 58'($signed(mx.prod[i][2])) + 58'(HALF_Q30);
      r = 28'(acc >>> 30);
      if (r > HI) begin
        r = HI;
        out_sat_nxt = 1'b1;
      end else if (r < LO) begin
        r = LO;
        out_sat_nxt = 1'b1;
      end
      out_data_nxt[i * COMP_W +: COMP_W] = r[COMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= mx.vld;
    end
    if (ce) begin
      out_data_r <= out_data_nxt;
      out_sat_r  <= out_sat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

// ===== rtl/rvaa_front.sv =====
// unit axis (square root and division) and sine/cosine pipeline
module rvaa_front import rvaa_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ce,
  input  logic            in_vld,
  input  logic [IN_W-1:0] in_data,
  output fe_t             fe_out
);

  fe_t stg_r   [0:FE_STAGES-1];
  fe_t stg_nxt [0:FE_STAGES-1];

  always_comb begin
    logic signed [COMP_W-1:0] a;
    logic [COMP_W-1:0]        m;
    logic [47:0]              sq;
    logic [31:0]              p;
    stg_nxt[0]     = '0;
    stg_nxt[0].vld = in_vld;
    for (int i = 0; i < 3; i++) begin
      a  = $signed(in_data[(3 + i) * COMP_W +: COMP_W]);
      m  = a[COMP_W-1] ? COMP_W'(-a) : COMP_W'(a);
      sq = m * m;
      stg_nxt[0].vec[i] = in_data[i * COMP_W +: COMP_W];
      stg_nxt[0].neg[i] = a[COMP_W-1];
      stg_nxt[0].mag[i] = 32'(m);
      stg_nxt[0].len    = stg_nxt[0].len + 64'(sq);
    end
    p = {in_data[6 * COMP_W +: ANGLE_W], {(32 - ANGLE_W){1'b0}}};
    stg_nxt[0].flip = p[31] ^ p[30];
    p[31]           = p[31] ^ stg_nxt[0].flip;
    stg_nxt[0].cz   = $signed({p[31], p});
    stg_nxt[0].cx   = CORDIC_START;
    stg_nxt[0].cy   = '0;
  end

  for (genvar k = 1; k < FE_STAGES; k++) begin : g_st
    if (k == S_H) begin : g_h
      always_comb begin
        fe_t t;
        t      = stg_r[k-1];
        t.zero = (t.len == '0);
        t.h    = '0;
        for (int i = 0; i < 32; i++) begin
          if (t.len[2*i +: 2] != 2'b00) t.h = 5'(31 - i);
        end
        stg_nxt[k] = t;
      end
    end else if (k == S_SH) begin : g_sh
      always_comb begin
        fe_t t;
        t     = stg_r[k-1];
        t.len = t.len << {t.h, 1'b0};
        for (int i = 0; i < 3; i++) t.mag[i] = t.mag[i] << t.h;
        t.res = '0;
        stg_nxt[k] = t;
      end
    end else if (k < S_NUM) begin : g_sq
      always_comb begin
        fe_t t;
        t = stg_r[k-1];
        if (k - S_SQ0 < CORDIC_STAGES) t = cordic_step(t, k - S_SQ0);
        t = sqrt_step(t, k - S_SQ0);
        stg_nxt[k] = t;
      end
    end else if (k == S_NUM) begin : g_num
      always_comb begin
        fe_t t;
        t = stg_r[k-1];
        for (int i = 0; i < 3; i++) begin
          t.dn[i]  = {t.mag[i][31:0], 30'd0} + 63'(t.res[31:1]);
          t.rem[i] = t.dn[i][62:31];
          t.q[i]   = '0;
        end
        stg_nxt[k] = t;
      end
    end else begin : g_dv
      always_comb stg_nxt[k] = div_step(stg_r[k-1], k - S_DV0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FE_STAGES; k++) stg_r[k].vld <= 1'b0;
    end else if (ce) begin
      for (int k = 0; k < FE_STAGES; k++) stg_r[k] <= stg_nxt[k];
    end
  end

  assign fe_out = stg_r[FE_STAGES-1];

endmodule

// ===== rtl/rvaa_matrix.sv =====
// rotation matrix build and matrix by vector products
module rvaa_matrix import rvaa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic ce,
  input  fe_t  fe_in,
  output mx_t  mx_out
);

  logic [4:0] vld_r;
  logic signed [COMP_W-1:0] vec0_r [3];
  logic signed [COMP_W-1:0] vec1_r [3];
  logic signed [COMP_W-1:0] vec2_r [3];
  logic signed [COMP_W-1:0] vec3_r [3];
  logic signed [31:0] n_r [3];
  logic signed [31:0] c0_r, s0_r, c1_r, c2_r;
  logic signed [32:0] omc0_r, omc1_r;
  logic signed [35:0] pp_r [6];
  logic signed [35:0] ns1_r [3];
  logic signed [35:0] ns2_r [3];
  logic signed [35:0] tm_r [6];
  logic signed [31:0] m_r [3][3];
  logic [2:0][2:0][55:0] prod_r;

  // pair order: xx yy zz xy xz yz
  localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

  always_ff @(posedge clk) begin
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] c;
    logic signed [35:0] e;
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[3:0], fe_in.vld};
    end
    if (ce) begin
      // unit axis and sine/cosine
      for (int i = 0; i < 3; i++) begin
        if (fe_in.zero) n_r[i] <= '0;
        else if (fe_in.neg[i]) n_r[i] <= -$signed({1'b0, fe_in.q[i]});
        else n_r[i] <= $signed({1'b0, fe_in.q[i]});
        vec0_r[i] <= $signed(fe_in.vec[i]);
      end
      x = clamp30(36'(fe_in.cx));
      y = clamp30(36'(fe_in.cy));
      c = fe_in.flip ? -x : x;
      c0_r   <= c;
      s0_r   <= fe_in.flip ? -y : y;
      omc0_r <= 33'(ONE_Q30) - 33'(c);
      // axis products
      for (int p = 0; p < 6; p++) pp_r[p] <= rnd30(66'(n_r[PA[p]] * n_r[PB[p]]));
      for (int i = 0; i < 3; i++) begin
        ns1_r[i]  <= rnd30(66'(n_r[i] * s0_r));
        vec1_r[i] <= vec0_r[i];
      end
      c1_r   <= c0_r;
      omc1_r <= omc0_r;
      // scaled by one minus cosine
      for (int p = 0; p < 6; p++) tm_r[p] <= rnd30(66'(pp_r[p]) * 66'(omc1_r));
      for (int i = 0; i < 3; i++) begin
        ns2_r[i]  <= ns1_r[i];
        vec2_r[i] <= vec1_r[i];
      end
      c2_r <= c1_r;
      // matrix entries
      for (int i = 0; i < 3; i++) begin
        e = tm_r[i] + 36'(c2_r);
        m_r[i][i] <= clamp30(e);
        vec3_r[i] <= vec2_r[i];
      end
      m_r[0][1] <= clamp30(tm_r[3] - ns2_r[2]);
      m_r[1][0] <= clamp30(tm_r[3] + ns2_r[2]);
      m_r[0][2] <= clamp30(tm_r[4] + ns2_r[1]);
      m_r[2][0] <= clamp30(tm_r[4] - ns2_r[1]);
      m_r[1][2] <= clamp30(tm_r[5] - ns2_r[0]);
      m_r[2][1] <= clamp30(tm_r[5] + ns2_r[0]);
      // entry by component
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) prod_r[i][j] <= 56'(m_r[i][j] * vec3_r[j]);
      end
    end
  end

  assign mx_out.vld  = vld_r[4];
  assign mx_out.prod = prod_r;

endmodule

// ===== rtl/rvaa_checker.sv =====
// port checker for the axis rotation block, bound to the top level
module rvaa_checker import rvaa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !in_tready |=> $stable(in_tready) || out_tready)
    else $error("pipeline released without output taken");

endmodule

bind vector_rotate_about_axis rvaa_checker u_rvaa_checker (.*);

// ===== bench/rotation_checker.sv =====
// checker for the axis rotation block: predicts each rotated vector and compares
`timescale 1ns / 1ps
module rotation_checker import rvaa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tuser,
  output int               fail_count,
  output int               pending_count,
  output int               result_count,
  output int               sat_count
);

  typedef struct packed {
    logic                  sat;
    logic [OUT_W-1:0]      rot;
  } rotated_t;

  rotated_t rotated_q[$];

  function automatic longint fshift(longint v, int n);
    if (v >= 0) return v >>> n;
    return -((-(v + 1)) >>> n) - 1;
  endfunction

  function automatic longint clampq(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return fshift(a * b + 64'sd536870912, 30);
  endfunction

  function automatic rotated_t predict_rotation(logic [IN_W-1:0] d);
    longint v[3], a[3], n[3], m[3][3], c, s, omc, x, y, z, dx, dy, acc, r;
    longint hi, lo;
    logic [63:0] mg[3], len, rt, bitv, rem, num;
    logic [31:0] p;
    logic flip;
    int h;
    rotated_t res;
    hi = (64'sd1 <<< (COMP_W - 1)) - 1;
    lo = -hi - 1;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(d[i*COMP_W +: COMP_W]));
      a[i] = longint'($signed(d[(3+i)*COMP_W +: COMP_W]));
    end
    len = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = a[i] < 0 ? -a[i] : a[i];
      len += mg[i] * mg[i];
    end
    if (len == 0) begin
      n[0] = 0; n[1] = 0; n[2] = 0;
    end else begin
      h = 0;
      while (len[63:62] == 2'b00) begin
        len = len << 2;
        h++;
      end
      rem = len; rt = 0; bitv = 64'd1 << 62;
      while (bitv != 0) begin
        if (rem >= rt + bitv) begin
          rem = rem - (rt + bitv);
          rt = (rt >> 1) + bitv;
        end else begin
          rt = rt >> 1;
        end
        bitv = bitv >> 2;
      end
      for (int i = 0; i < 3; i++) begin
        num = ((mg[i] << h) << 30) + (rt >> 1);
        n[i] = a[i] < 0 ? -longint'(num / rt) : longint'(num / rt);
      end
    end
    p = {d[6*COMP_W +: ANGLE_W], {(32-ANGLE_W){1'b0}}};
    flip = (p[31:30] == 2'b01) || (p[31:30] == 2'b10);
    if (flip) p[31] = ~p[31];
    x = 652032874; y = 0; z = longint'($signed(p));
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN[i]);
      end
    end
    x = clampq(x); y = clampq(y);
    c = flip ? -x : x;
    s = flip ? -y : y;
    omc = 64'sd1073741824 - c;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = mulq(mulq(n[i], n[j]), omc) + (i == j ? c : 0);
    m[0][1] -= mulq(n[2], s); m[1][0] += mulq(n[2], s);
    m[0][2] += mulq(n[1], s); m[2][0] -= mulq(n[1], s);
    m[1][2] -= mulq(n[0], s); m[2][1] += mulq(n[0], s);
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += clampq(m[i][j]) * v[j];
      r = fshift(acc + 64'sd536870912, 30);
      if (r > hi) begin r = hi; res.sat = 1'b1; end
      if (r < lo) begin r = lo; res.sat = 1'b1; end
      res.rot[i*COMP_W +: COMP_W] = r[COMP_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d",
             result_count, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0; result_count = 0; sat_count = 0;
  end

  assign pending_count = rotated_q.size();

  always @(posedge clk) begin
    rotated_t want;
    if (rst_n && in_tvalid && in_tready) rotated_q.push_back(predict_rotation(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      if (rotated_q.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = rotated_q.pop_front();
        for (int i = 0; i < 3; i++)
          if (out_tdata[i*COMP_W +: COMP_W] !== want.rot[i*COMP_W +: COMP_W])
            report_mismatch(i == 0 ? "rot_x" : (i == 1 ? "rot_y" : "rot_z"),
                            $signed(out_tdata[i*COMP_W +: COMP_W]),
                            $signed(want.rot[i*COMP_W +: COMP_W]));
        if (out_tuser !== want.sat) report_mismatch("saturated", out_tuser, want.sat);
        if (want.sat) sat_count++;
      end
      result_count++;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// testbench top for the axis rotation block: stimulus, flow control and verdict
`timescale 1ns / 1ps
module testbench import rvaa_pkg::*;;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  int               fail_count, pending_count, result_count, sat_count;
  int               hold_cycles;

  localparam logic [COMP_W-1:0] CMAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic [COMP_W-1:0] CMIN = {1'b1, {(COMP_W-1){1'b0}}};
  localparam logic [COMP_W-1:0] CONE = 24'd4096;
  localparam int  RANDOM_ITEMS = 1230;

  vector_rotate_about_axis i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  rotation_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count, .pending_count, .result_count, .sat_count
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return COMP_W'($urandom);
      1: return COMP_W'($signed($urandom_range(0, 16384)) - 8192);
      2: return $urandom_range(0, 1) ? CMAX : CMIN;
      3: return COMP_W'($signed($urandom_range(0, 2048)) - 1024);
      4: return '0;
      default: return COMP_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3) << 14) + 16'($signed($urandom_range(0, 4)) - 2);
      default: return ANGLE_W'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [IN_W-1:0] d);
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] pack_item(logic [COMP_W-1:0] vx, vy, vz, ax, ay, az,
                                                logic [ANGLE_W-1:0] ang);
    return {ang, az, ay, ax, vz, vy, vx};
  endfunction

  // receiver: random stalls at first, a long hold-off once, then its own stall pattern
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    hold_cycles = 0;
    while (result_count < 40) begin
      out_tready <= ($urandom_range(0, 3) != 0);
      @(negedge clk);
    end
    out_tready <= 1'b0;
    while (hold_cycles < 300) begin
      @(negedge clk);
      hold_cycles++;
    end
    forever begin
      case ($urandom_range(0, 3))
        0: out_tready <= 1'b1;
        1: out_tready <= 1'b0;
        default: out_tready <= ($urandom_range(0, 2) != 0);
      endcase
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  initial begin
    logic [ANGLE_W-1:0] angs[8];
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    angs = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h8001, 16'h2000, 16'hFFFF};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // directed: quarter turns, zero axis, extremes, saturation
    foreach (angs[k]) send_item(pack_item(CONE, 24'd2 * CONE, CMIN + 24'd1, '0, '0, CONE, angs[k]));
    send_item(pack_item(CONE, CONE, CONE, '0, '0, '0, 16'h2000));
    send_item(pack_item(CMAX, CMIN, CMAX, '0, '0, '0, 16'h0000));
    send_item(pack_item(CMAX, CMAX, CMAX, CONE, '0, '0, 16'h2000));
    send_item(pack_item(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 16'h1000));
    send_item(pack_item(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 16'h5555));
    send_item(pack_item(CMAX, CMIN, '0, 24'd1, 24'hFFFFFF, 24'd1, 16'h4000));
    send_item(pack_item(CMIN, CMAX, CONE, 24'd1, '0, '0, 16'h8000));
    send_item(pack_item(CONE, '0, '0, CMIN, 24'd1, CMAX, 16'h6000));
    send_item(pack_item(24'hFFFFFF, 24'd1, 24'hFFFFFF, '0, CMIN, '0, 16'hC000));
    send_item(pack_item(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                        24'hAAAAAA, 16'hAAAA));
    send_item(pack_item(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                        24'h555555, 16'h5555));
    send_gap();
    for (int i = 0; i < RANDOM_ITEMS; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && i < RANDOM_ITEMS; b++, i++)
        send_item(pack_item(rand_comp(), rand_comp(), rand_comp(),
                            rand_comp(), rand_comp(), rand_comp(), rand_angle()));
      if ($urandom_range(0, 2) != 0) send_gap();
    end
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d rotated vectors checked, %0d of them saturated", result_count, sat_count);
    $display("covered quarter turns, zero and extreme axes, bursts and a long output hold");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
